FILE: rtl/omvs_pkg.sv
// ----------------------------------------------------------------------------
// omvs_pkg
// Shared constants and types for the online mean/variance/stderr block.
// ----------------------------------------------------------------------------
`default_nettype none
package omvs_pkg;
   localparam int FRAC_BITS_DEF    = 16;
   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int CNT_W  = 32;
   localparam int M2_W   = 64;
   localparam int VAR_W  = 48;
   localparam int SE_W   = 32;
   localparam int OUT_W  = 32;

   // divider command and status
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [32:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_sts_type;
endpackage
`default_nettype wire

FILE: rtl/omvs_div.sv
// ----------------------------------------------------------------------------
// omvs_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module omvs_div
   import omvs_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  div_cmd_type cmd,
   output div_sts_type sts
);
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]} - {1'b0, dsr_ff};
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dsr_in  = cmd.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;
endmodule
`default_nettype wire

FILE: rtl/omvs_sqrt.sv
// ----------------------------------------------------------------------------
// omvs_sqrt
// Digit-by-digit integer square root of a 64-bit value.
// ----------------------------------------------------------------------------
`default_nettype none
module omvs_sqrt
   import omvs_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] val_ff, val_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] shifted;
   logic [33:0] trial;

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[31:0], val_ff[63:62]};
      trial   = shifted - {root_ff, 2'b01};
      if (start) begin
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[61:0], 2'b00};
         if (shifted >= {root_ff, 2'b01}) begin
            rem_in  = trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

FILE: rtl/omvs_mul.sv
// ----------------------------------------------------------------------------
// omvs_mul
// 64x64 product shifted right by FRAC_BITS with saturation, built from four
// 32x32 partial products, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module omvs_mul
   import omvs_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)(
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [63:0] op_a,
   input  wire  [63:0] op_b,
   output logic        done,
   output logic [63:0] result
);
   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [31:0]  pa, pb;
   logic [63:0]  prod_ff;
   logic [1:0]   sel_ff;
   logic         add_ff;
   logic [127:0] shifted;

   always_comb begin
      pa = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      pb = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (add_ff)
         acc_in = acc_ff + ({64'd0, prod_ff} << (7'd32 * ({5'd0, sel_ff[1]} + {5'd0, sel_ff[0]})));
      if (start) begin
         a_in = op_a;
         b_in = op_b;
         acc_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         add_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         add_ff  <= busy_ff && !cnt_ff[2] && !start;
         cnt_ff  <= cnt_in;
      end
      prod_ff <= pa * pb;
      sel_ff  <= cnt_ff[1:0];
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
   end

   assign shifted = acc_ff >> FRAC_BITS;
   assign done    = done_ff;
   assign result  = (shifted[127:64] != '0) ? '1 : shifted[63:0];
endmodule
`default_nettype wire

FILE: rtl/online_mean_variance_stderr.sv
// ----------------------------------------------------------------------------
// online_mean_variance_stderr
// Welford running mean, sample variance and standard error accumulator.
// ----------------------------------------------------------------------------
// Usage: one signed sample per request on the req_ stream (req_tdata). For
// each request one result leaves on the rsp_ stream: count, mean, variance,
// standard error and a valid flag (count >= 2).
// The time from an accepted request to rsp_tvalid is set by the shared
// one-bit-per-cycle divider, used for the mean step and, once two samples
// are in, for M2/(n-1) and variance/n, by the four partial products of the
// multiplier and by the square root, which is skipped (standard error
// saturates) when variance/n is too large. The block takes one request at a time.
// req_tready is high only when no sample is in work and the result register
// is empty. A stalled receiver holds the result in rsp_tdata; the next
// request is taken the cycle after it leaves.
// Reset (synchronous, high) clears count, mean and M2 to zero.
// ----------------------------------------------------------------------------
`default_nettype none
module online_mean_variance_stderr
   import omvs_pkg::*;
#(
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [31:0]  req_tdata,   // [31:0] sample
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [143:0] rsp_tdata,   // [31:0] sample_count, [63:32] running_mean,
                                     // [111:64] sample_variance, [143:112] standard_error
   output logic         rsp_tuser    // stats_valid
);
   localparam logic [3:0] ST_IDLE = 4'd0, ST_MDIV = 4'd1, ST_MWAIT = 4'd2,
      ST_MUL = 4'd3, ST_MULW = 4'd4, ST_VDIV = 4'd5, ST_VWAIT = 4'd6,
      ST_SDIV = 4'd7, ST_SWAIT = 4'd8, ST_SQ = 4'd9, ST_SQW = 4'd10, ST_OUT = 4'd11;

   logic [3:0]  st_ff, st_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [SAMPLE_WIDTH-1:0] mean_ff, mean_in;
   logic [M2_W-1:0] m2_ff, m2_in;
   logic signed [SAMPLE_WIDTH:0] x_ff, x_in, delta_ff, delta_in;
   logic [VAR_W-1:0] var_ff, var_in;
   logic [SE_W-1:0]  se_ff, se_in;
   logic rv_ff, rv_in;
   logic [143:0] rd_ff, rd_in;
   logic ru_ff, ru_in;

   div_cmd_type dcmd;
   div_sts_type dsts;
   logic mstart, mdone, sstart, sdone;
   logic [63:0] mop_a, mop_b, mres, sqin;
   logic [31:0] sroot;

   logic signed [SAMPLE_WIDTH:0] xs, e2, mag_d, mag_e, qs;
   logic signed [SAMPLE_WIDTH-1:0] newmean;
   logic [64:0] m2sum;
   logic term_ok;

   omvs_div u_div (.clock(clock), .reset(reset), .cmd(dcmd), .sts(dsts));
   omvs_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (.clock(clock), .reset(reset),
      .start(mstart), .op_a(mop_a), .op_b(mop_b), .done(mdone), .result(mres));
   omvs_sqrt u_sqrt (.clock(clock), .reset(reset), .start(sstart),
      .radicand(sqin), .done(sdone), .root(sroot));

   always_comb begin
      xs     = (SAMPLE_WIDTH+1)'(signed'(req_tdata[SAMPLE_WIDTH-1:0]));
      mag_d  = delta_ff[SAMPLE_WIDTH] ? -delta_ff : delta_ff;
      qs     = (SAMPLE_WIDTH+1)'(dsts.quotient);
      newmean = SAMPLE_WIDTH'(delta_ff[SAMPLE_WIDTH] ?
                  ((SAMPLE_WIDTH+1)'(mean_ff) - qs) : ((SAMPLE_WIDTH+1)'(mean_ff) + qs));
      e2     = x_ff - (SAMPLE_WIDTH+1)'(mean_ff);
      mag_e  = e2[SAMPLE_WIDTH] ? -e2 : e2;
      term_ok = (delta_ff[SAMPLE_WIDTH] == e2[SAMPLE_WIDTH]) || (delta_ff == '0) || (e2 == '0);
      m2sum  = {1'b0, m2_ff} + {1'b0, mres};

      st_in = st_ff; cnt_in = cnt_ff; mean_in = mean_ff; m2_in = m2_ff;
      x_in = x_ff; delta_in = delta_ff; var_in = var_ff; se_in = se_ff;
      rv_in = rv_ff; rd_in = rd_ff; ru_in = ru_ff;
      dcmd = '0; mstart = 1'b0; sstart = 1'b0;
      mop_a = 64'(unsigned'(mag_d)); mop_b = 64'(unsigned'(mag_e));
      sqin = 64'(dsts.quotient) << FRAC_BITS;

      if (rv_ff && rsp_tready) rv_in = 1'b0;

      case (st_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               x_in     = xs;
               delta_in = xs - (SAMPLE_WIDTH+1)'(mean_ff);
               if (cnt_ff != '1) cnt_in = cnt_ff + 1'b1;
               st_in = ST_MDIV;
            end
         end
         ST_MDIV: begin
            dcmd.start = 1'b1;
            dcmd.dividend = 64'(unsigned'(mag_d));
            dcmd.divisor = {1'b0, cnt_ff};
            st_in = ST_MWAIT;
         end
         ST_MWAIT: if (dsts.done) begin
            mean_in = newmean;
            st_in = ST_MUL;
         end
         ST_MUL: begin
            mstart = 1'b1;
            st_in = ST_MULW;
         end
         ST_MULW: if (mdone) begin
            if (term_ok) m2_in = m2sum[64] ? '1 : m2sum[63:0];
            var_in = '0; se_in = '0;
            st_in = (cnt_ff >= 2) ? ST_VDIV : ST_OUT;
         end
         ST_VDIV: begin
            dcmd.start = 1'b1;
            dcmd.dividend = m2_ff;
            dcmd.divisor = {1'b0, cnt_ff - 1'b1};
            st_in = ST_VWAIT;
         end
         ST_VWAIT: if (dsts.done) begin
            var_in = (dsts.quotient[63:48] != '0) ? '1 : dsts.quotient[47:0];
            st_in = ST_SDIV;
         end
         ST_SDIV: begin
            dcmd.start = 1'b1;
            dcmd.dividend = 64'(var_ff);
            dcmd.divisor = {1'b0, cnt_ff};
            st_in = ST_SWAIT;
         end
         ST_SWAIT: if (dsts.done) begin
            if ((dsts.quotient >> (64 - FRAC_BITS)) != '0) begin
               se_in = '1;
               st_in = ST_OUT;
            end else begin
               st_in = ST_SQ;
            end
         end
         ST_SQ: begin
            sstart = 1'b1;
            st_in = ST_SQW;
         end
         ST_SQW: if (sdone) begin
            se_in = sroot;
            st_in = ST_OUT;
         end
         ST_OUT: if (!rv_ff) begin
            rv_in = 1'b1;
            rd_in = {se_ff, var_ff, 32'(mean_ff), cnt_ff};
            ru_in = (cnt_ff >= 2);
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         cnt_ff  <= '0;
         mean_ff <= '0;
         m2_ff   <= '0;
         rv_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         cnt_ff  <= cnt_in;
         mean_ff <= mean_in;
         m2_ff   <= m2_in;
         rv_ff   <= rv_in;
      end
      x_ff     <= x_in;
      delta_ff <= delta_in;
      var_ff   <= var_in;
      se_ff    <= se_in;
      rd_ff    <= rd_in;
      ru_ff    <= ru_in;
   end

   assign req_tready = (st_ff == ST_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tuser  = ru_ff;

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && cnt_ff != '1) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("count did not advance");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> !req_tready)
      else $error("ready while busy");
   a_valid_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[111:64] == '0))
      else $error("variance without valid");
endmodule
`default_nettype wire
